// File: rtl/inverse_square_pair_force_macros.svh
// Assertion macros used by the inverse-square pair force back end.
`ifndef INVERSE_SQUARE_PAIR_FORCE_MACROS_SVH
`define INVERSE_SQUARE_PAIR_FORCE_MACROS_SVH
`ifndef SYNTHESIS
`define ISP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("isp assertion failed");
`define ISP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isp assertion failed");
`else
`define ISP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ISP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/isp_pkg.sv
// Shared widths, codes and types of the inverse-square pair force block.
package isp_pkg;
  localparam int POS_W     = 24;
  localparam int MASS_W    = 24;
  localparam int K_W       = 24;
  localparam int MD_W      = 52;
  localparam int FORCE_W   = 32;
  localparam int FRAC_OUT  = 16;
  localparam int D2_SHIFT  = 24;
  localparam int AD_W      = POS_W + 1;
  localparam int SQ_W      = 2 * AD_W;
  localparam int S_W       = SQ_W + 2;
  localparam int D2_W      = (S_W > MD_W) ? S_W : MD_W;
  localparam int X_W       = D2_W + D2_SHIFT;
  localparam int L_W       = X_W / 2;
  localparam int REM_W     = L_W + 3;
  localparam int MM_W      = 2 * MASS_W;
  localparam int NP_W      = K_W + MASS_W;
  localparam int N_W       = K_W + MM_W;
  localparam int Q_W       = D2_W + L_W;
  localparam int ND_W      = N_W + AD_W;
  localparam int NUM_W     = ND_W + FRAC_OUT;
  localparam int QB        = FORCE_W + 1;
  localparam int CMP_W     = Q_W + QB;
  localparam int DIV_LAT   = QB + 1;
  localparam int D2_LO     = D2_W / 2;
  localparam int D2_HI     = D2_W - D2_LO;
  localparam int L_LO      = L_W / 2;
  localparam int L_HI      = L_W - L_LO;
  localparam int N_T       = N_W / 3;
  localparam int N_TOP     = N_W - 2 * N_T;
  localparam int PQ_W      = D2_HI + L_HI;
  localparam int PN_W      = N_TOP + AD_W;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 6 * POS_W + 2 * MASS_W;
  localparam int OUT_DATA_W = 6 * FORCE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_D2   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

  typedef struct packed {
    logic [2:0][AD_W-1:0] ad;
    logic [2:0]           dneg;
    logic [MASS_W-1:0]    mass_a;
    logic [MASS_W-1:0]    mass_b;
    logic                 a_free;
    logic                 b_free;
    logic                 act;
  } item_t;

  typedef struct packed {
    logic       act;
    logic       a_free;
    logic       b_free;
    logic       zero;
    logic       kneg;
    logic [2:0] dneg;
  } ctx_t;

  typedef struct packed {
    logic [2:0][FORCE_W-1:0] force_b;
    logic [2:0][FORCE_W-1:0] force_a;
    logic                    active;
    logic                    saturated;
  } result_t;
endpackage

// File: rtl/isp_front.sv
// Front end: unpack a pair, form offsets and classify it for the back end.
module isp_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [isp_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                       s_tuser,
  input  logic                             enable,
  input  logic                             full,
  output logic                             push,
  output isp_pkg::item_t                   item
);
  logic signed [isp_pkg::AD_W-1:0] d [3];
  logic act;

  assign s_tready = !full;
  assign push     = s_tvalid && !full;
  assign act      = enable && (s_tuser[0] || s_tuser[1]);

  always_comb begin
    item = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = isp_pkg::AD_W'($signed(s_tdata[i*isp_pkg::POS_W +: isp_pkg::POS_W]))
           - isp_pkg::AD_W'($signed(s_tdata[(i+3)*isp_pkg::POS_W +: isp_pkg::POS_W]));
      item.dneg[i] = d[i][isp_pkg::AD_W-1];
      item.ad[i]   = d[i][isp_pkg::AD_W-1] ? isp_pkg::AD_W'(-d[i]) : isp_pkg::AD_W'(d[i]);
    end
    item.mass_a = s_tdata[6*isp_pkg::POS_W +: isp_pkg::MASS_W];
    item.mass_b = s_tdata[6*isp_pkg::POS_W + isp_pkg::MASS_W +: isp_pkg::MASS_W];
    item.a_free = s_tuser[0] && act;
    item.b_free = s_tuser[1] && act;
    item.act    = act;
  end
endmodule

// File: rtl/isp_queue.sv
// Short queue between the front end and the back end.
module isp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  isp_pkg::item_t wdata,
  output logic           full,
  input  logic           pop,
  output isp_pkg::item_t rdata,
  output logic           nonempty
);
  isp_pkg::item_t mem [isp_pkg::QDEPTH];
  logic [isp_pkg::QPTR_W-1:0] wp, rp;
  logic [isp_pkg::QPTR_W:0]   cnt;
  logic do_push, do_pop;

  assign full     = (cnt == (isp_pkg::QPTR_W+1)'(isp_pkg::QDEPTH));
  assign nonempty = (cnt != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

// File: rtl/isp_div.sv
// Pipelined restoring divider: one quotient bit per stage plus overflow check.
module isp_div (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [isp_pkg::NUM_W-1:0]   num,
  input  logic [isp_pkg::Q_W-1:0]     den,
  output logic [isp_pkg::QB-1:0]      mag,
  output logic                        ovf
);
  logic [isp_pkg::CMP_W-1:0] r  [isp_pkg::QB+1];
  logic [isp_pkg::Q_W-1:0]   d  [isp_pkg::QB+1];
  logic [isp_pkg::QB-1:0]    qb [isp_pkg::QB+1];
  logic                      ov [isp_pkg::QB+1];
  logic [isp_pkg::CMP_W-1:0] t  [isp_pkg::QB];
  logic                      ge [isp_pkg::QB];

  always_comb begin
    for (int k = 0; k < isp_pkg::QB; k++) begin
      t[k]  = isp_pkg::CMP_W'(d[k]) << (isp_pkg::QB - 1 - k);
      ge[k] = (r[k] >= t[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r[0]  <= isp_pkg::CMP_W'(num);
      d[0]  <= den;
      qb[0] <= '0;
      ov[0] <= (isp_pkg::CMP_W'(num) >= {den, isp_pkg::QB'(0)});
      for (int k = 0; k < isp_pkg::QB; k++) begin
        r[k+1]  <= ge[k] ? (r[k] - t[k]) : r[k];
        d[k+1]  <= d[k];
        qb[k+1] <= qb[k] | (ge[k] ? (isp_pkg::QB'(1) << (isp_pkg::QB - 1 - k)) : '0);
        ov[k+1] <= ov[k];
      end
    end
  end

  assign mag = qb[isp_pkg::QB];
  assign ovf = ov[isp_pkg::QB];
endmodule

// File: rtl/isp_back.sv
// Back end: distance, square root, products, division and saturation pipeline.
`include "inverse_square_pair_force_macros.svh"
module isp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  isp_pkg::item_t                     in_item,
  input  logic signed [isp_pkg::K_W-1:0]     strength,
  input  logic [isp_pkg::MD_W-1:0]           min_d2,
  output logic                               out_valid,
  input  logic                               out_ready,
  output isp_pkg::result_t                   out_res
);
  localparam int ISQ0    = 2;
  localparam int ISQ_END = ISQ0 + isp_pkg::L_W;
  localparam int M1      = ISQ_END + 1;
  localparam int M2      = M1 + 1;
  localparam int NST     = M2 + isp_pkg::DIV_LAT + 1;

  logic adv;
  logic [NST-1:0] vp;
  isp_pkg::ctx_t  cp [NST];

  // first stages
  logic [2:0][isp_pkg::AD_W-1:0] ad1, ad2;
  logic [2:0][isp_pkg::SQ_W-1:0] sq1;
  logic [isp_pkg::MM_W-1:0]      mm1;
  logic [isp_pkg::D2_W-1:0]      d2_2;
  logic [isp_pkg::NP_W-1:0]      nlo2, nhi2;
  logic [isp_pkg::S_W-1:0]       ssum;
  logic [isp_pkg::D2_W-1:0]      d2c;
  logic [isp_pkg::K_W-1:0]       kabs;

  // square root stages
  logic [isp_pkg::L_W-1:0]            rt   [isp_pkg::L_W+1];
  logic [isp_pkg::REM_W-1:0]          rm   [isp_pkg::L_W+1];
  logic [isp_pkg::D2_W-1:0]           d2i  [isp_pkg::L_W+1];
  logic [isp_pkg::N_W-1:0]            ni   [isp_pkg::L_W+1];
  logic [2:0][isp_pkg::AD_W-1:0]      adi  [isp_pkg::L_W+1];
  logic [isp_pkg::L_W-1:0]            rt_next [isp_pkg::L_W];
  logic [isp_pkg::REM_W-1:0]          rm_next [isp_pkg::L_W];
  logic [isp_pkg::X_W-1:0]            xv   [isp_pkg::L_W];
  logic [isp_pkg::REM_W-1:0]          cur  [isp_pkg::L_W];
  logic [isp_pkg::REM_W-1:0]          trl  [isp_pkg::L_W];

  // product stages
  logic [isp_pkg::PQ_W-1:0]           pq [4];
  logic [2:0][2:0][isp_pkg::PN_W-1:0] pn;
  logic [isp_pkg::Q_W-1:0]            q2;
  logic [2:0][isp_pkg::ND_W-1:0]      nd2;
  logic [isp_pkg::D2_W-1:0]           dm;
  logic [isp_pkg::L_W-1:0]            lm;
  logic [isp_pkg::N_W-1:0]            nm;

  logic [2:0][isp_pkg::QB-1:0] mag;
  logic [2:0]                  ovf;
  isp_pkg::result_t            res_next;

  function automatic logic [isp_pkg::FORCE_W:0] emit(
    input logic [isp_pkg::QB-1:0] m_in,
    input logic                   o_in,
    input logic                   neg
  );
    logic [isp_pkg::QB-1:0] lim;
    logic [isp_pkg::QB-1:0] m;
    logic                   sat;
    lim = neg ? (isp_pkg::QB'(1) << (isp_pkg::FORCE_W - 1))
              : (isp_pkg::QB'(1) << (isp_pkg::FORCE_W - 1)) - 1'b1;
    sat = o_in || (m_in > lim);
    m   = sat ? lim : m_in;
    return {sat, neg ? isp_pkg::FORCE_W'(-m) : isp_pkg::FORCE_W'(m)};
  endfunction

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid bits travel with the whole pipeline; hold on stall
  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vp        <= {vp[NST-2:0], in_valid};
      out_valid <= vp[NST-1];
    end
  end

  assign ssum = isp_pkg::S_W'(sq1[0]) + isp_pkg::S_W'(sq1[1]) + isp_pkg::S_W'(sq1[2]);
  assign d2c  = (isp_pkg::D2_W'(ssum) < isp_pkg::D2_W'(min_d2)) ? isp_pkg::D2_W'(min_d2)
                                                              : isp_pkg::D2_W'(ssum);
  assign kabs = strength[isp_pkg::K_W-1] ? isp_pkg::K_W'(-strength) : isp_pkg::K_W'(strength);

  always_comb begin
    for (int g = 0; g < isp_pkg::L_W; g++) begin
      xv[g]  = {d2i[g], isp_pkg::D2_SHIFT'(0)};
      cur[g] = {rm[g][isp_pkg::REM_W-3:0], xv[g][2*(isp_pkg::L_W-1-g) +: 2]};
      trl[g] = isp_pkg::REM_W'({rt[g], 2'b01});
      if (cur[g] >= trl[g]) begin
        rm_next[g] = cur[g] - trl[g];
        rt_next[g] = {rt[g][isp_pkg::L_W-2:0], 1'b1};
      end else begin
        rm_next[g] = cur[g];
        rt_next[g] = {rt[g][isp_pkg::L_W-2:0], 1'b0};
      end
    end
  end

  assign dm = d2i[isp_pkg::L_W];
  assign lm = rt[isp_pkg::L_W];
  assign nm = ni[isp_pkg::L_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      // context: offset signs, free flags, then zero and strength sign
      cp[0] <= '{act: in_item.act, a_free: in_item.a_free, b_free: in_item.b_free,
                 zero: 1'b0, kneg: 1'b0, dneg: in_item.dneg};
      cp[1] <= '{act: cp[0].act, a_free: cp[0].a_free, b_free: cp[0].b_free,
                 zero: (d2c == '0), kneg: strength[isp_pkg::K_W-1], dneg: cp[0].dneg};
      for (int k = 2; k < NST; k++) begin
        cp[k] <= cp[k-1];
      end
      // squares and mass product
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= in_item.ad[i] * in_item.ad[i];
      end
      ad1 <= in_item.ad;
      mm1 <= in_item.mass_a * in_item.mass_b;
      // clamp and strength partial products
      d2_2 <= d2c;
      ad2  <= ad1;
      nlo2 <= kabs * mm1[isp_pkg::MASS_W-1:0];
      nhi2 <= kabs * mm1[isp_pkg::MM_W-1:isp_pkg::MASS_W];
      // square root, one root bit per stage
      rt[0]  <= '0;
      rm[0]  <= '0;
      d2i[0] <= d2_2;
      ni[0]  <= isp_pkg::N_W'(nlo2) + (isp_pkg::N_W'(nhi2) << isp_pkg::MASS_W);
      adi[0] <= ad2;
      for (int g = 0; g < isp_pkg::L_W; g++) begin
        rt[g+1]  <= rt_next[g];
        rm[g+1]  <= rm_next[g];
        d2i[g+1] <= d2i[g];
        ni[g+1]  <= ni[g];
        adi[g+1] <= adi[g];
      end
      // partial products of D2*L and n*|d|
      pq[0] <= isp_pkg::PQ_W'(dm[isp_pkg::D2_LO-1:0] * lm[isp_pkg::L_LO-1:0]);
      pq[1] <= isp_pkg::PQ_W'(dm[isp_pkg::D2_LO-1:0] * lm[isp_pkg::L_W-1:isp_pkg::L_LO]);
      pq[2] <= isp_pkg::PQ_W'(dm[isp_pkg::D2_W-1:isp_pkg::D2_LO] * lm[isp_pkg::L_LO-1:0]);
      pq[3] <= isp_pkg::PQ_W'(dm[isp_pkg::D2_W-1:isp_pkg::D2_LO]
                              * lm[isp_pkg::L_W-1:isp_pkg::L_LO]);
      for (int i = 0; i < 3; i++) begin
        pn[i][0] <= isp_pkg::PN_W'(nm[isp_pkg::N_T-1:0] * adi[isp_pkg::L_W][i]);
        pn[i][1] <= isp_pkg::PN_W'(nm[2*isp_pkg::N_T-1:isp_pkg::N_T] * adi[isp_pkg::L_W][i]);
        pn[i][2] <= isp_pkg::PN_W'(nm[isp_pkg::N_W-1:2*isp_pkg::N_T] * adi[isp_pkg::L_W][i]);
      end
      // sum partial products
      q2 <= isp_pkg::Q_W'(pq[0])
          + (isp_pkg::Q_W'(pq[1]) << isp_pkg::L_LO)
          + (isp_pkg::Q_W'(pq[2]) << isp_pkg::D2_LO)
          + (isp_pkg::Q_W'(pq[3]) << (isp_pkg::D2_LO + isp_pkg::L_LO));
      for (int i = 0; i < 3; i++) begin
        nd2[i] <= isp_pkg::ND_W'(pn[i][0])
                + (isp_pkg::ND_W'(pn[i][1]) << isp_pkg::N_T)
                + (isp_pkg::ND_W'(pn[i][2]) << (2 * isp_pkg::N_T));
      end
      out_res <= res_next;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    isp_div u_div (
      .clk (clk),
      .adv (adv),
      .num ({nd2[i], isp_pkg::FRAC_OUT'(0)}),
      .den (q2),
      .mag (mag[i]),
      .ovf (ovf[i])
    );
  end

  // sign, free mask and saturation
  always_comb begin
    logic [isp_pkg::FORCE_W:0] ea, eb;
    logic bneg;
    res_next        = '0;
    res_next.active = cp[NST-1].act;
    for (int i = 0; i < 3; i++) begin
      bneg = cp[NST-1].kneg ^ cp[NST-1].dneg[i];
      eb   = emit(mag[i], ovf[i], bneg);
      ea   = emit(mag[i], ovf[i], !bneg);
      if (cp[NST-1].b_free && !cp[NST-1].zero) begin
        res_next.force_b[i] = eb[isp_pkg::FORCE_W-1:0];
        res_next.saturated  = res_next.saturated | eb[isp_pkg::FORCE_W];
      end
      if (cp[NST-1].a_free && !cp[NST-1].zero) begin
        res_next.force_a[i] = ea[isp_pkg::FORCE_W-1:0];
        res_next.saturated  = res_next.saturated | ea[isp_pkg::FORCE_W];
      end
    end
  end

  `ISP_ASSERT_NOW(a_inactive_zero, clk, rst, out_valid && !out_res.active, out_res.force_a == '0 && out_res.force_b == '0 && !out_res.saturated)
  `ISP_ASSERT_NXT(a_last_to_out, clk, rst, vp[NST-1] && adv, out_valid)
  `ISP_ASSERT_NXT(a_zero_dist, clk, rst, vp[NST-1] && adv && cp[NST-1].zero, out_res.force_a == '0 && out_res.force_b == '0 && !out_res.saturated)
endmodule

// File: rtl/inverse_square_pair_force.sv
// An accepted pair passes through the queue, then through the back end pipeline up to and
//   including the output register, to its result on the master side.
// Throughput: one pair per cycle while m_tready does not stall the output; the 38-stage
//   square root (one root bit per stage) and the three 34-stage dividers are fully pipelined.
// A four-entry queue separates the front end from the back end pipeline.
// Reset (rst, synchronous): clears valid bits and the queue, and loads
//   strength = 1.0, min_distance_squared = 1.0, enable = 1. No clearing pass.
module inverse_square_pair_force (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, mass_a, mass_b (lowest first)
  input  logic [isp_pkg::IN_DATA_W-1:0]     s_tdata,
  // a_free, b_free (lowest first)
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // force_a_x, force_a_y, force_a_z, force_b_x, force_b_y, force_b_z (lowest first)
  output logic [isp_pkg::OUT_DATA_W-1:0]    m_tdata,
  // active, saturated (lowest first)
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic [isp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [isp_pkg::MD_W-1:0]          cfg_data
);
  // configuration registers; the user must write them only while the block is idle (not enforced here)
  logic signed [isp_pkg::K_W-1:0] strength;
  logic [isp_pkg::MD_W-1:0]       min_d2;
  logic                           enable;

  logic           push, full, nonempty, back_ready;
  isp_pkg::item_t f_item, q_item;
  isp_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= isp_pkg::K_W'(4096);
      min_d2   <= isp_pkg::MD_W'(16777216);
      enable   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isp_pkg::CFG_STRENGTH: strength <= cfg_data[isp_pkg::K_W-1:0];
        isp_pkg::CFG_MIN_D2:   min_d2   <= cfg_data;
        isp_pkg::CFG_ENABLE:   enable   <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front end: offsets, absolute values and free/active classification
  isp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .enable   (enable),
    .full     (full),
    .push     (push),
    .item     (f_item)
  );

  // decouple front and back so each can stall on its own
  isp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (f_item),
    .full     (full),
    .pop      (back_ready),
    .rdata    (q_item),
    .nonempty (nonempty)
  );

  // back end: the arithmetic pipeline ending in the output register
  isp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nonempty),
    .in_ready  (back_ready),
    .in_item   (q_item),
    .strength  (strength),
    .min_d2    (min_d2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.force_b[2], res.force_b[1], res.force_b[0],
                    res.force_a[2], res.force_a[1], res.force_a[0]};
  assign m_tuser = {res.saturated, res.active};
endmodule

// File: tb/sv/inverse_square_pair_force_tb.sv
// Self-checking testbench for the inverse-square pair force block.
`timescale 1ns / 1ps

module inverse_square_pair_force_tb;
  import isp_pkg::*;

  typedef struct packed {
    logic [MASS_W-1:0]       mass_b;
    logic [MASS_W-1:0]       mass_a;
    logic [2:0][POS_W-1:0]   b_pos;   // x lowest
    logic [2:0][POS_W-1:0]   a_pos;   // x lowest
    logic                    b_free;
    logic                    a_free;
  } pair_t;

  typedef struct packed {
    logic [2:0][FORCE_W-1:0] force_b;
    logic [2:0][FORCE_W-1:0] force_a;
    logic                    saturated;
    logic                    active;
  } force_t;

  typedef struct {
    logic                 do_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [MD_W-1:0]      cfg_val;
    pair_t                pair;
    logic                 typed;
    force_t               want;
  } dir_row_t;

  localparam logic [MD_W-1:0] MD_MAX  = {MD_W{1'b1}};
  localparam logic [MD_W-1:0] ONE_Q24 = 52'd16777216;
  localparam int              SETTLE  = 100;  // comfortably past the pipeline depth

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [MD_W-1:0]       cfg_data;

  inverse_square_pair_force u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the register file, updated as each write goes out.
  logic [K_W-1:0]  strength_q;
  logic [MD_W-1:0] min_d2_q;
  logic            enable_q;

  force_t   pending_forces[$];
  dir_row_t dir_tbl[$];
  int       errors;
  int       burst_left;
  int       gap_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous bound: ~970 items with gaps and heavy receiver stalls stay far below this.
  initial begin
    #5ms;
    $display("inverse_square_pair_force test failed");
    $finish;
  end

  // Clip a magnitude to the signed output range and apply its sign.
  function automatic logic [FORCE_W-1:0] clip_force(input logic [127:0] mag, input logic neg,
                                                    inout logic sat);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? (128'd1 << (FORCE_W - 1)) : ((128'd1 << (FORCE_W - 1)) - 1);
    m = mag;
    if (mag > lim) begin
      m = lim;
      sat = 1'b1;
    end
    return neg ? (FORCE_W'(0) - m[FORCE_W-1:0]) : m[FORCE_W-1:0];
  endfunction

  // Work out the forces on both particles for the current register settings.
  function automatic force_t pair_forces(input pair_t p);
    force_t              r;
    logic signed [AD_W-1:0] d[3];
    logic [127:0]        ad[3];
    logic [127:0]        s, d2, x, cand, root, q, n, kabs, mag;
    logic                kneg, bneg, sat;
    r = '0;
    sat = 1'b0;
    if (!enable_q || !(p.a_free || p.b_free)) return r;
    r.active = 1'b1;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({p.a_pos[i][POS_W-1], p.a_pos[i]}) - $signed({p.b_pos[i][POS_W-1], p.b_pos[i]});
      ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      s = s + ad[i] * ad[i];
    end
    d2 = (s < 128'(min_d2_q)) ? 128'(min_d2_q) : s;
    if (d2 == 0) return r;  // coincident with no clamp: no force
    x = d2 << D2_SHIFT;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= x) root = cand;
    end
    q = d2 * root;
    kneg = strength_q[K_W-1];
    kabs = kneg ? (128'd0 - 128'($signed(strength_q))) : 128'(strength_q);
    n = kabs * 128'(p.mass_a) * 128'(p.mass_b);
    for (int i = 0; i < 3; i++) begin
      mag = ((n * ad[i]) << FRAC_OUT) / q;
      bneg = kneg != (d[i] < 0);
      // for positive strength B is pulled toward A, A the opposite way
      if (p.b_free) r.force_b[i] = clip_force(mag, bneg, sat);
      if (p.a_free) r.force_a[i] = clip_force(mag, !bneg, sat);
    end
    r.saturated = sat;
    return r;
  endfunction

  task automatic report(input string what, input logic [FORCE_W-1:0] want,
                        input logic [FORCE_W-1:0] got);
    $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  // Compare each delivered item with the oldest expectation.
  always @(posedge clk) begin
    force_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata, m_tuser};
      if (pending_forces.size() == 0) begin
        report("unexpected item", '0, '0);
      end else begin
        want = pending_forces.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.force_a[i] !== want.force_a[i])
            report($sformatf("force_a[%0d]", i), want.force_a[i], got.force_a[i]);
          if (got.force_b[i] !== want.force_b[i])
            report($sformatf("force_b[%0d]", i), want.force_b[i], got.force_b[i]);
        end
        if (got.active !== want.active)
          report("active", FORCE_W'(want.active), FORCE_W'(got.active));
        if (got.saturated !== want.saturated)
          report("saturated", FORCE_W'(want.saturated), FORCE_W'(got.saturated));
      end
    end
  end

  // Receiver backpressure: rotate through free-running, random, sparse and long-stall modes.
  initial begin
    int mode, cnt, hold;
    m_tready = 1'b0;
    cnt = 0;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = $urandom_range(20, 120);
      end
      cnt--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold == 0) hold = $urandom_range(1, 25);
          hold--;
          m_tready <= (hold == 0);
        end
      endcase
    end
  end

  // Drop valid and wait until every expected item has come back.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    gap_left = 0;
    wait (pending_forces.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MD_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STRENGTH: strength_q = val[K_W-1:0];
      CFG_MIN_D2:   min_d2_q = val;
      CFG_ENABLE:   enable_q = val[0];
      default: ;
    endcase
  endtask

  // Offer one pair in bursts with random gaps; hold it until accepted.
  task automatic send_pair(input pair_t p, input logic typed, input force_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    while (gap_left > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      gap_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {p.mass_b, p.mass_a, p.b_pos, p.a_pos};
    s_tuser <= {p.b_free, p.a_free};
    do @(posedge clk); while (!s_tready);
    pending_forces.push_back(typed ? want : pair_forces(p));
    burst_left--;
  endtask

  function automatic pair_t mk_pair(input int ax, ay, az, bx, by, bz,
                                    input int unsigned ma, mb, input logic af, bf);
    pair_t p;
    p.a_pos = {POS_W'(az), POS_W'(ay), POS_W'(ax)};
    p.b_pos = {POS_W'(bz), POS_W'(by), POS_W'(bx)};
    p.mass_a = MASS_W'(ma);
    p.mass_b = MASS_W'(mb);
    p.a_free = af;
    p.b_free = bf;
    return p;
  endfunction

  // Mostly nearby particles with moderate masses; sometimes fully random fields.
  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    p.a_free = 1'($urandom_range(0, 1));
    p.b_free = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 5) != 0 && !(p.a_free || p.b_free)) p.a_free = 1'b1;
    if ($urandom_range(0, 4) == 0) begin
      p.a_pos = (3 * POS_W)'({$urandom, $urandom, $urandom});
      p.b_pos = (3 * POS_W)'({$urandom, $urandom, $urandom});
      p.mass_a = MASS_W'($urandom);
      p.mass_b = MASS_W'($urandom);
    end else begin
      span = 1 << $urandom_range(8, 17);
      for (int i = 0; i < 3; i++) begin
        p.a_pos[i] = POS_W'($urandom_range(0, 2 * span) - span);
        p.b_pos[i] = POS_W'($urandom_range(0, 2 * span) - span);
      end
      p.mass_a = MASS_W'($urandom_range(0, 1 << $urandom_range(4, 16)));
      p.mass_b = MASS_W'($urandom_range(0, 1 << $urandom_range(4, 16)));
    end
    return p;
  endfunction

  task automatic add_row(input pair_t p, input logic typed = 1'b0, input force_t want = '0,
                         input logic do_cfg = 1'b0, input logic [CFG_IDX_W-1:0] idx = '0,
                         input logic [MD_W-1:0] val = '0);
    dir_row_t row;
    row.do_cfg = do_cfg;
    row.cfg_idx = idx;
    row.cfg_val = val;
    row.pair = p;
    row.typed = typed;
    row.want = want;
    dir_tbl.push_back(row);
  endtask

  initial begin
    force_t none, idle_on;
    logic [MD_W-1:0] md;
    none = '0;
    idle_on = '0;
    idle_on.active = 1'b1;
    errors = 0;
    burst_left = 0;
    gap_left = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_STRENGTH;
    cfg_data = '0;
    strength_q = 24'd4096;
    min_d2_q = ONE_Q24;
    enable_q = 1'b1;

    // Directed rows: defaults first, then field extremes and each special case.
    add_row(mk_pair(4096, 0, 0, 0, 0, 0, 4096, 4096, 1, 1));
    add_row(mk_pair(0, -8192, 4096, 0, 0, 0, 8192, 4096, 1, 1));
    add_row(mk_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                    24'hFFFFFF, 24'hFFFFFF, 1, 1));
    add_row(mk_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                    24'hFFFFFF, 24'hFFFFFF, 1, 1));
    add_row(mk_pair(100, 200, 300, -100, 0, 50, 24'hFFFFFF, 24'hFFFFFF, 1, 1));
    add_row(mk_pair(4096, 4096, 0, 0, 0, 0, 4096, 4096, 0, 0), 1'b1, none);
    add_row(mk_pair(4096, 4096, 0, 0, 0, 0, 4096, 4096, 1, 0));
    add_row(mk_pair(4096, 4096, 0, 0, 0, 0, 4096, 4096, 0, 1));
    add_row(mk_pair(777, -5, 9, 777, -5, 9, 4096, 4096, 1, 1), 1'b1, idle_on);
    add_row(mk_pair(4096, 0, 0, 0, 0, 0, 0, 4096, 1, 1), 1'b1, idle_on);
    // Zero clamp: coincident particles must give no force, not a divide fault.
    add_row(mk_pair(123, 456, 789, 123, 456, 789, 4096, 4096, 1, 1), 1'b1, idle_on,
            1'b1, CFG_MIN_D2, '0);
    add_row(mk_pair(1, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 1));
    add_row(mk_pair(4096, 8192, -4096, 0, 0, 0, 4096, 8192, 1, 1), 1'b0, none,
            1'b1, CFG_STRENGTH, 52'hF_FFFF_FF80_0000);  // most negative, stray high bits
    add_row(mk_pair(1, 1, 1, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 1));
    add_row(mk_pair(4096, 0, 0, 0, 0, 0, 4096, 4096, 1, 1), 1'b1, none,
            1'b1, CFG_ENABLE, 52'h2);  // bit 0 clear: disabled
    add_row(mk_pair(4096, 0, 0, 0, 0, 0, 4096, 4096, 1, 1), 1'b0, none,
            1'b1, CFG_ENABLE, 52'h1);
    add_row(mk_pair(8388607, 0, 0, -8388608, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 1), 1'b0, none,
            1'b1, CFG_STRENGTH, 52'd8388607);
    add_row(mk_pair(4096, 4096, 4096, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 1, 1), 1'b0, none,
            1'b1, CFG_MIN_D2, MD_MAX);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].do_cfg) write_reg(dir_tbl[i].cfg_idx, dir_tbl[i].cfg_val);
      send_pair(dir_tbl[i].pair, dir_tbl[i].typed, dir_tbl[i].want);
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_STRENGTH, 52'd4096);
          write_reg(CFG_MIN_D2, ONE_Q24);
          write_reg(CFG_ENABLE, 52'd1);
        end
        1: begin
          write_reg(CFG_STRENGTH, MD_W'({$urandom, $urandom}));
          md = MD_W'($urandom_range(0, 1 << 20));
          write_reg(CFG_MIN_D2, md);
        end
        2: begin
          write_reg(CFG_STRENGTH, 52'hF_FFFF_FF80_0000);
          write_reg(CFG_MIN_D2, '0);
        end
        3: begin
          write_reg(CFG_STRENGTH, 52'd8388607);
          write_reg(CFG_MIN_D2, MD_MAX);
        end
        4: begin
          write_reg(CFG_STRENGTH, '0);
          md = MD_W'({$urandom, $urandom});
          write_reg(CFG_MIN_D2, md);
        end
        5: begin
          write_reg(CFG_STRENGTH, MD_W'({$urandom, $urandom}));
          write_reg(CFG_ENABLE, 52'd0);
        end
        default: begin
          write_reg(CFG_ENABLE, 52'd1);
          write_reg(CFG_STRENGTH, 52'($urandom_range(0, 1 << 16)) - 52'd32768);
          write_reg(CFG_MIN_D2, 52'd1 << 20);
        end
      endcase
      for (int n = 0; n < 136; n++) begin
        // Hold off once, mid-way through phase 2, until everything in flight has come back.
        if (ph == 2 && n == 60) drain();
        send_pair(rand_pair(), 1'b0, '0);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending_forces.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("inverse_square_pair_force test passed");
    end else begin
      $display("inverse_square_pair_force test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/isp_pkg.sv
rtl/isp_front.sv
rtl/isp_queue.sv
rtl/isp_div.sv
rtl/isp_back.sv
rtl/inverse_square_pair_force.sv
tb/sv/inverse_square_pair_force_tb.sv
